### design/stlbg_pkg.sv
// Shared constants, types and sine table for the tone-lock beep generator.
`default_nettype none
package stlbg_pkg;

    localparam int PHASE_BITS_DEF      = 32;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam logic [2:0] REG_BASE_STEP  = 3'd0;
    localparam logic [2:0] REG_MAX_OFFSET = 3'd1;
    localparam logic [2:0] REG_THRESHOLD  = 3'd2;
    localparam logic [2:0] REG_HOLD       = 3'd3;
    localparam logic [2:0] REG_BEEP_STEP  = 3'd4;
    localparam logic [2:0] REG_BEEP_TICKS = 3'd5;
    localparam logic [2:0] REG_PAUSE      = 3'd6;
    localparam logic [2:0] REG_BASE_AMP   = 3'd7;

    localparam logic [30:0] RST_BASE_STEP  = 31'd62634971;
    localparam logic [23:0] RST_MAX_OFFSET = 24'd2684355;
    localparam logic [14:0] RST_THRESHOLD  = 15'd1638;
    localparam logic [19:0] RST_HOLD       = 20'd48000;
    localparam logic [30:0] RST_BEEP_STEP  = 31'd89478485;
    localparam logic [15:0] RST_BEEP_TICKS = 16'd5760;
    localparam logic [19:0] RST_PAUSE      = 20'd48000;
    localparam logic [13:0] RST_BASE_AMP   = 14'd3277;

    localparam logic [63:0] SIN_C1 = 64'd1686629713;
    localparam logic [63:0] SIN_C3 = 64'd693598668;
    localparam logic [63:0] SIN_C5 = 64'd85569278;
    localparam logic [63:0] SIN_C7 = 64'd5026946;
    localparam logic [63:0] SIN_C9 = 64'd172270;

    typedef struct packed {
        logic [30:0] base_phase_step;
        logic [23:0] max_offset_step;
        logic [14:0] lock_threshold;
        logic [19:0] lock_hold_ticks;
        logic [30:0] beep_phase_step;
        logic [15:0] beep_ticks;
        logic [19:0] pause_ticks;
        logic [13:0] base_amplitude;
    } cfg_t;

    // quarter-wave magnitude, evaluated at elaboration for each table entry
    function automatic logic [15:0] quarter_sine(input int r, input int qbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] y;
        x  = 64'(r) << (30 - qbits);
        x2 = (x * x) >> 30;
        p  = SIN_C9;
        p  = SIN_C7 - ((x2 * p) >> 30);
        p  = SIN_C5 - ((x2 * p) >> 30);
        p  = SIN_C3 - ((x2 * p) >> 30);
        p  = SIN_C1 - ((x2 * p) >> 30);
        y  = (x * p) >> 30;
        y  = (y + 64'd16384) >> 15;
        if (y > 64'd32767)
        begin
            y = 64'd32767;
        end
        return y[15:0];
    endfunction

endpackage
`default_nettype wire

### design/stlbg_sine.sv
// Registered sine lookup: quarter-wave table with quadrant folding.
`default_nettype none
module stlbg_sine #(
    parameter int PHASE_BITS      = stlbg_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = stlbg_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic [PHASE_BITS-1:0] phase,
    output logic signed [15:0]         sine
);
    localparam int QBITS = SINE_TABLE_BITS - 2;
    localparam int QLEN  = (1 << QBITS) + 1;

    logic [15:0] rom [QLEN];
    logic [SINE_TABLE_BITS-1:0] k;
    logic [1:0] quad;
    logic [QBITS:0] r;
    logic [15:0] mag;

    for (genvar i = 0; i < QLEN; i++)
    begin : g_rom
        assign rom[i] = stlbg_pkg::quarter_sine(i, QBITS);
    end

    assign k    = phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
    assign quad = k[SINE_TABLE_BITS-1 -: 2];
    assign r    = quad[0] ? ((QBITS+1)'(1) << QBITS) - {1'b0, k[QBITS-1:0]}
                          : {1'b0, k[QBITS-1:0]};
    assign mag  = rom[r];

    always_ff @(posedge clk)
    begin
        sine <= quad[1] ? -$signed(mag) : $signed(mag);
    end
endmodule
`default_nettype wire

### design/stlbg_cfg.sv
// Configuration register file.
`default_nettype none
module stlbg_cfg (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output stlbg_pkg::cfg_t  cfg
);
    stlbg_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_phase_step <= stlbg_pkg::RST_BASE_STEP;
            cfg_reg.max_offset_step <= stlbg_pkg::RST_MAX_OFFSET;
            cfg_reg.lock_threshold  <= stlbg_pkg::RST_THRESHOLD;
            cfg_reg.lock_hold_ticks <= stlbg_pkg::RST_HOLD;
            cfg_reg.beep_phase_step <= stlbg_pkg::RST_BEEP_STEP;
            cfg_reg.beep_ticks      <= stlbg_pkg::RST_BEEP_TICKS;
            cfg_reg.pause_ticks     <= stlbg_pkg::RST_PAUSE;
            cfg_reg.base_amplitude  <= stlbg_pkg::RST_BASE_AMP;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                stlbg_pkg::REG_BASE_STEP:  cfg_reg.base_phase_step <= cfg_data[30:0];
                stlbg_pkg::REG_MAX_OFFSET: cfg_reg.max_offset_step <= cfg_data[23:0];
                stlbg_pkg::REG_THRESHOLD:  cfg_reg.lock_threshold  <= cfg_data[14:0];
                stlbg_pkg::REG_HOLD:       cfg_reg.lock_hold_ticks <= cfg_data[19:0];
                stlbg_pkg::REG_BEEP_STEP:  cfg_reg.beep_phase_step <= cfg_data[30:0];
                stlbg_pkg::REG_BEEP_TICKS: cfg_reg.beep_ticks      <= cfg_data[15:0];
                stlbg_pkg::REG_PAUSE:      cfg_reg.pause_ticks     <= cfg_data[19:0];
                stlbg_pkg::REG_BASE_AMP:   cfg_reg.base_amplitude  <= cfg_data[13:0];
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

### design/stlbg_div.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
`default_nettype none
module stlbg_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [47:0] num,
    input  wire logic [31:0] den,
    output logic             done,
    output logic [47:0]      quo
);
    logic [47:0] q_reg, q_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] den_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;

    assign trial = {rem_reg, q_reg[47]};
    assign quo   = q_reg;
    assign done  = busy_reg && (cnt_reg == 6'd0);

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            q_next    = num;
            rem_next  = '0;
            cnt_next  = 6'd48;
            busy_next = 1'b1;
        end
        else if (busy_reg && cnt_reg != 6'd0)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = 32'(trial - {1'b0, den_reg});
                q_next   = {q_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                q_next   = {q_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
        end
        else if (busy_reg)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end
endmodule
`default_nettype wire

### design/stereo_tone_lock_beep_generator.sv
// Top level: tone-lock beep generator built around one shared 41x25 signed multiplier.
// One tick is processed at a time; s_tready is high only while the sequencer is idle. A tick
// takes longest during a beep, most of it spent in the 48-step divider that scales the beep
// envelope; the first tick of a beep segment also waits for the restarted beep phase to reach
// the sine table. The result sits in an output register, so the next tick is taken in the
// cycle after the result is loaded. While a result is stalled the following tick is still
// computed, then held in the final state.
`default_nettype none
module stereo_tone_lock_beep_generator #(
    parameter int PHASE_BITS      = stlbg_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = stlbg_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // delta
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // right channel in [31:16], left channel in [15:0]
    output logic             m_tuser,   // is_locked
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TGT   = 4'd1;
    localparam logic [3:0] S_SMOO  = 4'd2;
    localparam logic [3:0] S_LOCK  = 4'd3;
    localparam logic [3:0] S_AMP   = 4'd4;
    localparam logic [3:0] S_TL    = 4'd5;
    localparam logic [3:0] S_TR    = 4'd6;
    localparam logic [3:0] S_BSEG  = 4'd7;
    localparam logic [3:0] S_BM1   = 4'd8;
    localparam logic [3:0] S_BM2   = 4'd9;
    localparam logic [3:0] S_BDIV  = 4'd10;
    localparam logic [3:0] S_BWAIT = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    stlbg_pkg::cfg_t cfg;

    logic [3:0]  state_reg, state_next;
    logic [PHASE_BITS-1:0] lph_reg, rph_reg, bph_reg;
    logic signed [39:0] smo_reg;
    logic [20:0] stable_reg;
    logic        locked_reg;
    logic [20:0] cpos_reg;
    logic [1:0]  lseg_reg;
    logic signed [16:0] d_reg;
    logic [16:0] mag_reg;
    logic [14:0] amp_reg;
    logic signed [15:0] left_reg, right_reg;
    logic [1:0]  seg_reg;
    logic [16:0] spos_reg;
    logic        sub_reg;
    logic signed [63:0] acc_reg;
    logic        neg_reg;
    logic [31:0] tdata_reg;
    logic        tuser_reg;
    logic        out_load;
    logic [PHASE_BITS-1:0] sin_ph;
    logic signed [15:0] sine;

    // shared multiplier
    logic signed [40:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [65:0] prod;

    logic        div_start, div_done;
    logic [47:0] div_num, div_quo;
    logic [31:0] div_den;

    logic [16:0] den17;
    logic [17:0] bt2;
    logic [21:0] cyc_len;

    stlbg_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
    );

    stlbg_sine #(.PHASE_BITS(PHASE_BITS), .SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sine (
        .clk(clk), .phase(sin_ph), .sine(sine)
    );

    stlbg_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
        .done(div_done), .quo(div_quo)
    );

    assign den17   = (cfg.beep_ticks > 16'd1) ? {1'b0, cfg.beep_ticks} - 17'd1 : 17'd1;
    assign bt2     = {1'b0, cfg.beep_ticks, 1'b0};
    assign cyc_len = 22'(bt2) + 22'(cfg.pause_ticks);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign out_load = (state_reg == S_OUT) && (!m_tvalid || m_tready);

    always_comb
    begin
        sin_ph = lph_reg;
        if (state_reg == S_TL)
        begin
            sin_ph = rph_reg;
        end
        else if (state_reg == S_BSEG || state_reg == S_BM1)
        begin
            sin_ph = bph_reg;
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_TGT:  begin mul_a = 41'(d_reg); mul_b = $signed({1'b0, cfg.max_offset_step}); end
            S_SMOO: begin mul_a = 41'(acc_reg); mul_b = 25'sd1311; end
            S_AMP:  begin mul_a = $signed(41'(cfg.base_amplitude));
                          mul_b = $signed(25'(17'd65536 - mag_reg)); end
            S_TL, S_TR: begin mul_a = 41'(sine); mul_b = $signed(25'(amp_reg)); end
            S_BM1:  begin mul_a = 41'(sine); mul_b = $signed(25'({cfg.base_amplitude, 1'b0})); end
            S_BM2:  begin mul_a = 41'(acc_reg); mul_b = $signed(25'(den17 - spos_reg)); end
            default: ;
        endcase
    end
    assign prod = mul_a * mul_b;

    assign div_start = (state_reg == S_BDIV);
    assign div_num   = (neg_reg ? 48'(-acc_reg) : 48'(acc_reg)) + 48'(div_den >> 1);
    assign div_den   = 32'(den17) << 15;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            lph_reg    <= '0;
            rph_reg    <= '0;
            bph_reg    <= '0;
            smo_reg    <= '0;
            stable_reg <= '0;
            locked_reg <= 1'b0;
            cpos_reg   <= '0;
            lseg_reg   <= 2'd3;
            tdata_reg  <= '0;
            tuser_reg  <= 1'b0;
            m_tvalid   <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                m_tvalid <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        d_reg     <= 17'($signed(s_tdata));
                        mag_reg   <= s_tdata[15] ? 17'(-17'($signed(s_tdata)))
                                                 : {1'b0, s_tdata};
                        left_reg  <= '0;
                        right_reg <= '0;
                        state_reg <= S_TGT;
                    end
                end
                S_TGT:
                begin
                    // floor(d*max/256) - smoothed
                    acc_reg   <= 64'(prod >>> 8) - 64'(smo_reg);
                    state_reg <= S_SMOO;
                end
                S_SMOO:
                begin
                    smo_reg   <= smo_reg + 40'((prod + 66'sd32768) >>> 16);
                    state_reg <= S_LOCK;
                end
                S_LOCK:
                begin
                    if (mag_reg < {2'b0, cfg.lock_threshold})
                    begin
                        if (stable_reg != 21'h1FFFFF)
                        begin
                            stable_reg <= stable_reg + 21'd1;
                        end
                        if (!locked_reg && (stable_reg + 21'd1 >= 21'(cfg.lock_hold_ticks)
                            || stable_reg == 21'h1FFFFF))
                        begin
                            locked_reg <= 1'b1;
                            cpos_reg   <= '0;
                            lseg_reg   <= 2'd3;
                            bph_reg    <= '0;
                            state_reg  <= S_BSEG;
                        end
                        else
                        begin
                            state_reg <= locked_reg ? S_BSEG : S_AMP;
                        end
                    end
                    else
                    begin
                        stable_reg <= '0;
                        locked_reg <= 1'b0;
                        cpos_reg   <= '0;
                        lseg_reg   <= 2'd3;
                        state_reg  <= S_AMP;
                    end
                end
                S_AMP:
                begin
                    amp_reg   <= 15'((prod + 66'sd32768) >>> 16);
                    state_reg <= S_TL;
                end
                S_TL:
                begin
                    left_reg  <= 16'((prod + 66'sd16384) >>> 15);
                    lph_reg   <= lph_reg + PHASE_BITS'(cfg.base_phase_step);
                    state_reg <= S_TR;
                end
                S_TR:
                begin
                    right_reg <= 16'((prod + 66'sd16384) >>> 15);
                    rph_reg   <= rph_reg + PHASE_BITS'(cfg.base_phase_step)
                               + PHASE_BITS'(smo_reg >>> 7);
                    state_reg <= S_OUT;
                end
                S_BSEG:
                begin
                    if (22'(cpos_reg) < 22'(cfg.beep_ticks))
                    begin
                        seg_reg  <= 2'd0;
                        spos_reg <= 17'(cpos_reg);
                        sub_reg  <= (lseg_reg != 2'd0);
                        if (lseg_reg != 2'd0)
                        begin
                            lseg_reg <= 2'd0;
                            bph_reg  <= '0;
                        end
                        state_reg <= S_BM1;
                    end
                    else if (22'(cpos_reg) < 22'(bt2))
                    begin
                        seg_reg  <= 2'd1;
                        spos_reg <= 17'(cpos_reg - 21'(cfg.beep_ticks));
                        sub_reg  <= (lseg_reg != 2'd1);
                        if (lseg_reg != 2'd1)
                        begin
                            lseg_reg <= 2'd1;
                            bph_reg  <= '0;
                        end
                        state_reg <= S_BM1;
                    end
                    else
                    begin
                        seg_reg   <= 2'd2;
                        lseg_reg  <= 2'd2;
                        sub_reg   <= 1'b0;
                        state_reg <= S_OUT;
                    end
                end
                S_BM1:
                begin
                    // sine registered from the phase before a reset reads stale: restart
                    if (sub_reg)
                    begin
                        sub_reg <= 1'b0;
                    end
                    else
                    begin
                        acc_reg   <= 64'(prod);
                        state_reg <= S_BM2;
                    end
                end
                S_BM2:
                begin
                    acc_reg   <= 64'(prod);
                    neg_reg   <= prod < 0;
                    bph_reg   <= bph_reg + PHASE_BITS'(cfg.beep_phase_step);
                    state_reg <= S_BDIV;
                end
                S_BDIV:
                begin
                    state_reg <= S_BWAIT;
                end
                S_BWAIT:
                begin
                    if (div_done)
                    begin
                        if (seg_reg == 2'd0)
                        begin
                            left_reg <= neg_reg ? 16'(-div_quo) : div_quo[15:0];
                        end
                        else
                        begin
                            right_reg <= neg_reg ? 16'(-div_quo) : div_quo[15:0];
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        if (locked_reg)
                        begin
                            if (22'(cpos_reg) + 22'd1 >= cyc_len)
                            begin
                                cpos_reg <= '0;
                            end
                            else
                            begin
                                cpos_reg <= cpos_reg + 21'd1;
                            end
                        end
                        tdata_reg <= {right_reg, left_reg};
                        tuser_reg <= locked_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### design/stlbg_checker.sv
// Port-level checker for the tone-lock beep generator, with its bind.
`default_nettype none
module stlbg_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tuser
);
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready) else $error("input taken while busy");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !$isunknown({m_tdata, m_tuser})) else $error("result has unknown bits");
endmodule

bind stereo_tone_lock_beep_generator stlbg_checker u_stlbg_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire
